### sv/mlfq_pkg.sv
`timescale 1ns / 1ps

package mlfq_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned TIME_W = 40;
  localparam int unsigned QU_W   = 24;
  localparam int unsigned RT_W   = 32;
  localparam int unsigned NOW_W  = 64;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned QPROD_W = QU_W + LVL_W + 1;

  localparam logic [STAT_W-1:0] STAT_UNUSED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LOADING = 3'd1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 2'd2;

  localparam logic [1:0] REG_QUANTUM_UNIT  = 2'd0;
  localparam logic [1:0] REG_RESET_PERIOD  = 2'd1;
  localparam logic [1:0] REG_SHELL_ID      = 2'd2;
  localparam logic [1:0] REG_USER_ID_START = 2'd3;

  localparam logic [QU_W-1:0]  QUANTUM_UNIT_RST  = 24'd100000;
  localparam logic [PER_W-1:0] RESET_PERIOD_RST  = 32'd10000000;
  localparam logic [ID_W-1:0]  SHELL_ID_RST      = 16'd1;
  localparam logic [ID_W-1:0]  USER_ID_START_RST = 16'd2;

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_SET       = 3'd1,
    CMD_FREE      = 3'd2,
    CMD_FREE_USER = 3'd3,
    CMD_CHARGE    = 3'd4,
    CMD_TICK      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_left;
    logic [LVL_W-1:0]  level;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ID_W-1:0]   target_id;
    logic [STAT_W-1:0] new_status;
    logic [RT_W-1:0]   run_time;
    logic              tty_pending;
    logic              reset_due;
    logic              found;
    logic [ID_W-1:0]   next_id;
    logic [QU_W-1:0]   quantum_unit;
    logic [ID_W-1:0]   shell_id;
    logic [ID_W-1:0]   user_id_start;
  } scan_ctx_t;

  typedef struct packed {
    logic             we;
    logic             hit;
    logic [LVL_W-1:0] hit_level;
    logic             dres;
    entry_t           entry;
  } scan_upd_t;

endpackage

### sv/mlfq_process_table_core.sv
`timescale 1ns / 1ps
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: cmd, target_id, new_status,
//           |     |                        |   run_time, now_time, tty_pending
// m_axis    | out | m_axis_tvalid/tready   | tdata: result_id, result_level,
//           |     |                        |   error_code, did_reset
// apb       | in  | psel/penable/pready    | paddr, pwrite, pwdata, prdata
// A command passes through the transfer cycle, a setup state, a scan of every table
// entry through the shared entry update unit and the entry RAM read port, and a state
// that posts the result. s_axis_tready is high only between commands.
// Reset is asynchronous, active low; all entries read as unused after reset.
// A result waits in the output register while m_axis_tready is low; the next
// command can be taken, and its result is held back until that transfer ends.

module mlfq_process_table_core #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned LEVEL_COUNT   = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] cmd, [18:3] target_id, [21:19] new_status, [53:22] run_time,
  // [117:54] now_time, [118] tty_pending, [119] zero
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] result_id, [18:16] result_level, [20:19] error_code, [21] did_reset,
  // [23:22] zero
  output logic [23:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_ENTRIES - 1);

  mlfq_pkg::state_e state_q, state_d;

  logic [mlfq_pkg::QU_W-1:0]  quantum_unit_q;
  logic [mlfq_pkg::PER_W-1:0] reset_period_q;
  logic [mlfq_pkg::ID_W-1:0]  shell_id_q;
  logic [mlfq_pkg::ID_W-1:0]  user_id_start_q;
  logic [mlfq_pkg::ID_W-1:0]  id_counter_q;
  logic [mlfq_pkg::NOW_W-1:0] last_reset_q;

  logic [2:0]                  cmd_q;
  logic [mlfq_pkg::ID_W-1:0]   tid_q;
  logic [mlfq_pkg::STAT_W-1:0] nstat_q;
  logic [mlfq_pkg::RT_W-1:0]   rt_q;
  logic [mlfq_pkg::NOW_W-1:0]  now_q;
  logic                        tty_q;
  logic                        reset_due_q;

  logic [IdxW-1:0]            proc_q;
  logic                       found_q;
  logic                       dres_q;
  logic [mlfq_pkg::LVL_W-1:0] lvl_q;

  logic        m_valid_q;
  logic [23:0] m_data_q;

  logic                       in_xfer;
  logic                       cfg_wr;
  logic                       rd_en;
  logic [IdxW-1:0]            rd_addr;
  logic                       ram_we;
  logic                       out_load;
  logic [mlfq_pkg::ID_W-1:0]  next_id;
  logic [mlfq_pkg::NOW_W-1:0] elapsed;

  mlfq_pkg::entry_t    rd_entry;
  mlfq_pkg::scan_ctx_t ctx;
  mlfq_pkg::scan_upd_t upd;

  logic [mlfq_pkg::ID_W-1:0]  res_id;
  logic [mlfq_pkg::LVL_W-1:0] res_lvl;
  logic [mlfq_pkg::ERR_W-1:0] res_err;
  logic                       res_dres;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign next_id = id_counter_q + 1'b1;
  assign elapsed = now_q - last_reset_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = mlfq_pkg::ST_PREP;
        end
      end
      mlfq_pkg::ST_PREP: state_d = mlfq_pkg::ST_SCAN;
      mlfq_pkg::ST_SCAN: begin
        if (proc_q == IdxLast) begin
          state_d = mlfq_pkg::ST_DONE;
        end
      end
      mlfq_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = mlfq_pkg::ST_IDLE;
        end
      end
      default: state_d = mlfq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      mlfq_pkg::ST_IDLE: s_axis_tready = 1'b1;
      mlfq_pkg::ST_PREP: rd_en = 1'b1;
      mlfq_pkg::ST_SCAN: begin
        rd_en   = proc_q != IdxLast;
        rd_addr = proc_q + 1'b1;
        ram_we  = upd.we;
      end
      mlfq_pkg::ST_DONE: out_load = !m_valid_q || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_comb begin
    ctx               = '0;
    ctx.cmd           = cmd_q;
    ctx.target_id     = tid_q;
    ctx.new_status    = nstat_q;
    ctx.run_time      = rt_q;
    ctx.tty_pending   = tty_q;
    ctx.reset_due     = reset_due_q;
    ctx.found         = found_q;
    ctx.next_id       = next_id;
    ctx.quantum_unit  = quantum_unit_q;
    ctx.shell_id      = shell_id_q;
    ctx.user_id_start = user_id_start_q;
  end

  mlfq_entry_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry),
    .we_i      (ram_we),
    .wr_addr_i (proc_q),
    .wr_data_i (upd.entry)
  );

  mlfq_entry_unit #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_unit (
    .ctx_i (ctx),
    .ent_i (rd_entry),
    .upd_o (upd)
  );

  always_comb begin
    res_id   = tid_q;
    res_lvl  = '0;
    res_err  = mlfq_pkg::ERR_OK;
    res_dres = 1'b0;
    case (cmd_q)
      mlfq_pkg::CMD_ALLOC: begin
        res_id  = found_q ? next_id : '0;
        res_err = found_q ? mlfq_pkg::ERR_OK : mlfq_pkg::ERR_FULL;
      end
      mlfq_pkg::CMD_SET, mlfq_pkg::CMD_FREE, mlfq_pkg::CMD_CHARGE: begin
        res_lvl = found_q ? lvl_q : '0;
        res_err = found_q ? mlfq_pkg::ERR_OK : mlfq_pkg::ERR_NOT_FOUND;
      end
      mlfq_pkg::CMD_TICK: res_dres = dres_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= mlfq_pkg::ST_IDLE;
      quantum_unit_q  <= mlfq_pkg::QUANTUM_UNIT_RST;
      reset_period_q  <= mlfq_pkg::RESET_PERIOD_RST;
      shell_id_q      <= mlfq_pkg::SHELL_ID_RST;
      user_id_start_q <= mlfq_pkg::USER_ID_START_RST;
      id_counter_q    <= '0;
      last_reset_q    <= '0;
      proc_q          <= '0;
      found_q         <= 1'b0;
      dres_q          <= 1'b0;
      m_valid_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          mlfq_pkg::REG_QUANTUM_UNIT:  quantum_unit_q  <= pwdata[mlfq_pkg::QU_W-1:0];
          mlfq_pkg::REG_RESET_PERIOD:  reset_period_q  <= pwdata;
          mlfq_pkg::REG_SHELL_ID:      shell_id_q      <= pwdata[mlfq_pkg::ID_W-1:0];
          mlfq_pkg::REG_USER_ID_START: user_id_start_q <= pwdata[mlfq_pkg::ID_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == mlfq_pkg::ST_PREP) begin
        proc_q  <= '0;
        found_q <= 1'b0;
        dres_q  <= 1'b0;
      end
      if (state_q == mlfq_pkg::ST_SCAN) begin
        proc_q  <= proc_q + 1'b1;
        found_q <= found_q || upd.hit;
        dres_q  <= dres_q || upd.dres;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
        if (cmd_q == mlfq_pkg::CMD_ALLOC && found_q) begin
          id_counter_q <= next_id;
        end
        if (cmd_q == mlfq_pkg::CMD_TICK && dres_q) begin
          last_reset_q <= now_q;
        end
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= s_axis_tdata[2:0];
      tid_q   <= s_axis_tdata[18:3];
      nstat_q <= s_axis_tdata[21:19];
      rt_q    <= s_axis_tdata[53:22];
      now_q   <= s_axis_tdata[117:54];
      tty_q   <= s_axis_tdata[118];
    end
    if (state_q == mlfq_pkg::ST_PREP) begin
      reset_due_q <= elapsed >= mlfq_pkg::NOW_W'(reset_period_q);
    end
    if (state_q == mlfq_pkg::ST_SCAN && upd.hit && !found_q) begin
      lvl_q <= upd.hit_level;
    end
    if (out_load) begin
      m_data_q <= {2'b00, res_dres, res_err, res_lvl, res_id};
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mlfq_pkg::REG_QUANTUM_UNIT:  prdata = 32'(quantum_unit_q);
      mlfq_pkg::REG_RESET_PERIOD:  prdata = reset_period_q;
      mlfq_pkg::REG_SHELL_ID:      prdata = 32'(shell_id_q);
      mlfq_pkg::REG_USER_ID_START: prdata = 32'(user_id_start_q);
      default: prdata = '0;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### sv/mlfq_entry_ram.sv
`timescale 1ns / 1ps

module mlfq_entry_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_i,
  output mlfq_pkg::entry_t                    rd_data_o,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            wr_addr_i,
  input  mlfq_pkg::entry_t                    wr_data_i
);

  mlfq_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  mlfq_pkg::entry_t rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### sv/mlfq_entry_unit.sv
`timescale 1ns / 1ps

module mlfq_entry_unit #(
  parameter int unsigned LEVEL_COUNT = 5
) (
  input  mlfq_pkg::scan_ctx_t ctx_i,
  input  mlfq_pkg::entry_t    ent_i,
  output mlfq_pkg::scan_upd_t upd_o
);

  localparam logic [mlfq_pkg::LVL_W-1:0] LvlMax = mlfq_pkg::LVL_W'(LEVEL_COUNT - 1);

  logic                                live;
  logic                                id_match;
  logic [mlfq_pkg::LVL_W-1:0]          lvl_inc;
  logic [mlfq_pkg::QPROD_W-1:0]        q_prod;
  logic [mlfq_pkg::TIME_W-1:0]         q_zero;
  logic                                exhaust;
  logic [mlfq_pkg::TIME_W-1:0]         time_sub;

  assign live     = ent_i.status != mlfq_pkg::STAT_UNUSED;
  assign id_match = ent_i.id == ctx_i.target_id;
  assign lvl_inc  = (ent_i.level < LvlMax) ? ent_i.level + 1'b1 : ent_i.level;
  assign q_prod   = mlfq_pkg::QPROD_W'({1'b0, lvl_inc} + 4'd1)
                  * mlfq_pkg::QPROD_W'(ctx_i.quantum_unit);
  assign q_zero   = mlfq_pkg::TIME_W'(ctx_i.quantum_unit);
  assign exhaust  = mlfq_pkg::TIME_W'(ctx_i.run_time) >= ent_i.time_left;
  assign time_sub = ent_i.time_left - mlfq_pkg::TIME_W'(ctx_i.run_time);

  always_comb begin
    upd_o       = '0;
    upd_o.entry = ent_i;
    case (ctx_i.cmd)
      mlfq_pkg::CMD_ALLOC: begin
        if (!ctx_i.found && !live) begin
          upd_o.we              = 1'b1;
          upd_o.hit             = 1'b1;
          upd_o.entry.id        = ctx_i.next_id;
          upd_o.entry.status    = mlfq_pkg::STAT_LOADING;
          upd_o.entry.level     = '0;
          upd_o.entry.time_left = q_zero;
        end
      end
      mlfq_pkg::CMD_SET: begin
        if (id_match) begin
          upd_o.we           = 1'b1;
          upd_o.entry.status = ctx_i.new_status;
          upd_o.hit          = !ctx_i.found;
          upd_o.hit_level    = ent_i.level;
        end
      end
      mlfq_pkg::CMD_FREE: begin
        if (id_match) begin
          upd_o.we           = 1'b1;
          upd_o.entry.status = mlfq_pkg::STAT_UNUSED;
          upd_o.hit          = live && !ctx_i.found;
          upd_o.hit_level    = ent_i.level;
        end
      end
      mlfq_pkg::CMD_FREE_USER: begin
        if (ent_i.id >= ctx_i.user_id_start && live) begin
          upd_o.we           = 1'b1;
          upd_o.entry.status = mlfq_pkg::STAT_UNUSED;
        end
      end
      mlfq_pkg::CMD_CHARGE: begin
        if (id_match && live && !ctx_i.found) begin
          upd_o.we  = 1'b1;
          upd_o.hit = 1'b1;
          if (exhaust) begin
            upd_o.entry.level     = lvl_inc;
            upd_o.entry.time_left = mlfq_pkg::TIME_W'(q_prod);
            upd_o.hit_level       = lvl_inc;
          end else begin
            upd_o.entry.time_left = time_sub;
            upd_o.hit_level       = ent_i.level;
          end
        end
      end
      mlfq_pkg::CMD_TICK: begin
        if (!ctx_i.found && ent_i.id == ctx_i.shell_id) begin
          upd_o.hit = 1'b1;
          if (ctx_i.tty_pending && live) begin
            upd_o.we              = 1'b1;
            upd_o.entry.level     = '0;
            upd_o.entry.time_left = q_zero;
          end
        end
        if (ctx_i.reset_due && live) begin
          upd_o.we              = 1'b1;
          upd_o.dres            = 1'b1;
          upd_o.entry.level     = '0;
          upd_o.entry.time_left = q_zero;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
